>>> hdl/lwr_pkg.sv
// Shared types for the increasing-subsequence block.
// Used by the tail cells and the top level; depends on nothing.
package lwr_pkg;

	localparam int OUT_BITS = 32;

	typedef struct packed {
		logic lt;
		logic valid;
	} link_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} cell_ctl_t;

endpackage

>>> hdl/lis_with_reconstruction.sv
// Longest strictly increasing subsequence finder with reconstruction.
// Input channel: sample_value, end_of_sequence with sample_valid/sample_stall.
// Output channel: member_value, sequence_length, final_member with
// member_valid/member_stall. A word moves when valid is high and stall low.
// Each element is registered when taken and placed in the tail chain in the next
// cycle, with sample_stall high meanwhile; all tail cells compare in parallel.
// On an element flagged end_of_sequence the block walks the predecessor
// links back from the last tail, one link per cycle through the element and
// link RAMs, then emits the members in order, each word read out and then held
// until the receiver takes it; the payload holds while stalled.
// After the final member is taken the sequence state clears and the next
// element is taken in the following cycle. Elements beyond MAX_ELEMENTS are
// dropped, but their end flag still triggers the output.
// Reset clears the tail chain and the counters; RAM contents are undefined
// and never read before written. Depends on lwr_pkg, lwr_ram, lwr_cell.
module lis_with_reconstruction #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] sample_value,
	input  logic        end_of_sequence,
	input  logic        sample_valid,
	output logic        sample_stall,
	output logic [31:0] member_value,
	output logic [6:0]  sequence_length,
	output logic        final_member,
	output logic        member_valid,
	input  logic        member_stall
);

	localparam int PW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INS   = 3'd1;
	localparam logic [2:0] ST_RD0   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_ORD   = 3'd4;
	localparam logic [2:0] ST_OLD   = 3'd5;
	localparam logic [2:0] ST_OWAIT = 3'd6;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  eos_q;
	logic [CW-1:0]         elem_cnt_q;
	logic [CW-1:0]         tail_cnt_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         j_q;
	logic [PW-1:0]         last_pos_q;
	logic [31:0]           out_value_q;
	logic                  final_q;
	logic                  out_valid_q;

	logic [63:0]           in_wide;
	logic [63:0]           out_wide;
	logic                  accept;
	logic                  done;
	lwr_pkg::cell_ctl_t    ctl;

	lwr_pkg::link_t        links [MAX_ELEMENTS+1];
	logic [PW-1:0]         poss  [MAX_ELEMENTS+1];
	logic [PW-1:0]         preds [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] append_v;
	logic [MAX_ELEMENTS-1:0] last_v;
	logic [MAX_ELEMENTS:0]   valid_v;
	logic [PW-1:0]         pred_sel;

	logic [VALUE_BITS-1:0] elem_rd;
	logic [PW-1:0]         link_rd;
	logic [VALUE_BITS-1:0] mbuf_rd;
	logic [PW-1:0]         walk_addr;

	assign in_wide      = 64'($signed(sample_value));
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign done         = (state_q == ST_OWAIT) && !member_stall && final_q;
	assign ctl.upd      = (state_q == ST_INS);
	assign ctl.clr      = done;

	assign links[0].lt    = 1'b1;
	assign links[0].valid = 1'b1;
	assign poss[0]        = '0;
	assign valid_v[MAX_ELEMENTS] = 1'b0;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		assign valid_v[i] = links[i+1].valid;
		lwr_cell #(
			.VALUE_BITS(VALUE_BITS),
			.POS_BITS  (PW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.value     (value_q),
			.pos_in    (elem_cnt_q[PW-1:0]),
			.prev_link (links[i]),
			.prev_pos  (poss[i]),
			.next_valid(valid_v[i+1]),
			.link      (links[i+1]),
			.pos       (poss[i+1]),
			.pred      (preds[i]),
			.append    (append_v[i]),
			.is_last   (last_v[i])
		);
	end

	always_comb begin
		pred_sel = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			pred_sel = pred_sel | preds[i];
		end
	end

	assign walk_addr = (state_q == ST_RD0) ? last_pos_q : link_rd;

	lwr_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
		.clk  (clk),
		.we   (ctl.upd),
		.waddr(elem_cnt_q[PW-1:0]),
		.wdata(value_q),
		.raddr(walk_addr),
		.rdata(elem_rd)
	);

	lwr_ram #(.WIDTH(PW), .DEPTH(MAX_ELEMENTS)) u_link_ram (
		.clk  (clk),
		.we   (ctl.upd),
		.waddr(elem_cnt_q[PW-1:0]),
		.wdata(pred_sel),
		.raddr(walk_addr),
		.rdata(link_rd)
	);

	lwr_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_member_ram (
		.clk  (clk),
		.we   (state_q == ST_WALK),
		.waddr(PW'(k_q - CW'(1))),
		.wdata(elem_rd),
		.raddr(j_q[PW-1:0]),
		.rdata(mbuf_rd)
	);

	assign out_wide = 64'($signed(mbuf_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			elem_cnt_q  <= '0;
			tail_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (elem_cnt_q < CW'(MAX_ELEMENTS)) begin
							state_q <= ST_INS;
						end else if (end_of_sequence) begin
							state_q <= ST_RD0;
						end
					end
				end
				ST_INS: begin
					elem_cnt_q <= elem_cnt_q + CW'(1);
					if (|append_v) begin
						tail_cnt_q <= tail_cnt_q + CW'(1);
					end
					state_q <= eos_q ? ST_RD0 : ST_IDLE;
				end
				ST_RD0: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (k_q == CW'(1)) begin
						state_q <= ST_ORD;
					end
				end
				ST_ORD: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (!member_stall) begin
						out_valid_q <= 1'b0;
						if (final_q) begin
							elem_cnt_q <= '0;
							tail_cnt_q <= '0;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= in_wide[VALUE_BITS-1:0];
			eos_q   <= end_of_sequence;
		end
		if (ctl.upd && (|last_v)) begin
			last_pos_q <= elem_cnt_q[PW-1:0];
		end
		if (state_q == ST_RD0) begin
			k_q <= tail_cnt_q;
		end else if (state_q == ST_WALK) begin
			k_q <= k_q - CW'(1);
		end
		if (state_q == ST_WALK) begin
			j_q <= '0;
		end else if (state_q == ST_OWAIT && !member_stall) begin
			j_q <= j_q + CW'(1);
		end
		if (state_q == ST_OLD) begin
			out_value_q <= out_wide[lwr_pkg::OUT_BITS-1:0];
			final_q     <= ((j_q + CW'(1)) == tail_cnt_q);
		end
	end

	assign member_value    = out_value_q;
	assign sequence_length = 7'(tail_cnt_q);
	assign final_member    = final_q;
	assign member_valid    = out_valid_q;

endmodule

>>> hdl/lwr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module lwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/lwr_cell.sv
// One tail cell: holds a (value, position) tail and decides from its own
// compare and its left neighbor's whether the incoming element lands here.
// Depends on lwr_pkg.
module lwr_cell #(
	parameter int VALUE_BITS = 32,
	parameter int POS_BITS   = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lwr_pkg::cell_ctl_t    ctl,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [POS_BITS-1:0]   pos_in,
	input  lwr_pkg::link_t        prev_link,
	input  logic [POS_BITS-1:0]   prev_pos,
	input  logic                  next_valid,
	output lwr_pkg::link_t        link,
	output logic [POS_BITS-1:0]   pos,
	output logic [POS_BITS-1:0]   pred,
	output logic                  append,
	output logic                  is_last
);

	logic [VALUE_BITS-1:0] tail_q;
	logic [POS_BITS-1:0]   pos_q;
	logic                  valid_q;
	logic                  chosen;

	assign link.valid = valid_q;
	assign link.lt    = valid_q && ($signed(tail_q) < $signed(value));
	assign pos        = pos_q;
	assign chosen     = ctl.upd && prev_link.lt && !link.lt;
	assign append     = chosen && !valid_q;
	assign is_last    = chosen && !next_valid;
	assign pred       = chosen ? prev_pos : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (chosen) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (chosen) begin
			tail_q <= value;
			pos_q  <= pos_in;
		end
	end

endmodule
